@@ hw/rtl/fct_pkg.sv @@
`default_nettype none
package fct_pkg;

  localparam int NumPlanes = 6;
  localparam int FracBits  = 16;
  localparam int NumRegs   = 8;
  localparam int CoefW     = 34;
  localparam int RegW      = 64;
  localparam int RegIdxW   = 3;
  localparam int SumW      = 72;

  typedef enum logic [1:0] {
    FUNC_POINT  = 2'd0,
    FUNC_CUBE   = 2'd1,
    FUNC_SPHERE = 2'd2,
    FUNC_BOX    = 2'd3
  } func_e;

  // One plane as it travels through the cell chain
  typedef struct packed {
    logic signed [CoefW-1:0] a;
    logic signed [CoefW-1:0] b;
    logic signed [CoefW-1:0] c;
    logic signed [CoefW-1:0] d;
  } plane_t;

  // Operands of the transaction under test, already pre-scaled
  typedef struct packed {
    logic signed [33:0] px;   // x, or min+max for box
    logic signed [33:0] py;
    logic signed [33:0] pz;
    logic signed [33:0] ex;   // radius, or max-min for box (cube and box only)
    logic signed [33:0] ey;
    logic signed [33:0] ez;
    logic signed [33:0] dk;   // scale applied to d
    logic signed [33:0] rk;   // additive radius term (sphere)
    logic               use_ext;
  } oper_t;

  localparam logic [RegW-1:0] RegReset [NumRegs] = '{
    64'd65536, 64'd0, 64'd281474976710656, 64'd0,
    64'd0, 64'd65536, 64'd0, 64'd281474976710656
  };

endpackage
`default_nettype wire

@@ hw/rtl/frustum_cull_test.sv @@
`default_nettype none
// Frustum containment tester.
// Configuration: cfg_we_i/cfg_idx_i/cfg_data_i write one of eight 64-bit
// matrix registers (two Q16.16 entries each); the three-bit index reaches
// all eight. The six planes are rebuilt in the cycle after a write
// and held in a ring of six cells.
// Input: a transaction is accepted when start_i is high and busy_o is low.
// func_i selects point, cube, sphere or box; x/y/z, radius and max_* are
// the operands. busy_o rises the cycle after acceptance.
// While a transaction runs, the ring rotates once per cycle, feeding one plane
// into the evaluator. Each query passes the ring shifts, the product register,
// the cull accumulate and the result register. inside_res_o is valid with
// done_o, which is high for one cycle. busy_o falls at the end of that cycle,
// so a new transaction is accepted only once the last one's result is out.
// The receiver cannot stall; done_o is a single-cycle strobe.
// Reset loads the planes of the identity matrix and clears all control.
module frustum_cull_test (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [fct_pkg::RegIdxW-1:0]       cfg_idx_i,
  input  wire logic [fct_pkg::RegW-1:0]          cfg_data_i,
  input  wire logic                              start_i,
  output logic                                   busy_o,
  input  wire logic [1:0]                        func_i,
  input  wire logic signed [31:0]                x_i,
  input  wire logic signed [31:0]                y_i,
  input  wire logic signed [31:0]                z_i,
  input  wire logic [30:0]                       radius_i,
  input  wire logic signed [31:0]                max_x_i,
  input  wire logic signed [31:0]                max_y_i,
  input  wire logic signed [31:0]                max_z_i,
  output logic                                   done_o,
  output logic                                   inside_res_o
);
  import fct_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_WAIT = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [RegW-1:0] regs_q [NumRegs];
  logic            rebuild_q;
  logic [2:0]      cnt_q, cnt_d;
  oper_t           op_q;
  logic            cull_q;
  logic            inside_q, done_q;
  plane_t          ring [NumPlanes];
  plane_t          derived [NumPlanes];
  logic            shift, accept, ev_vld, ev_neg;
  logic [1:0]      pend_q;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);

  // matrix registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) regs_q[i] <= RegReset[i];
      rebuild_q <= 1'b1;
    end else begin
      rebuild_q <= cfg_we_i;
      if (cfg_we_i) regs_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // plane derivation: r4 +/- r1..r3
  always_comb begin
    logic signed [CoefW-1:0] m [4][4];
    for (int r = 0; r < 4; r++) begin
      m[r][0] = CoefW'($signed(regs_q[2*r][31:0]));
      m[r][1] = CoefW'($signed(regs_q[2*r][63:32]));
      m[r][2] = CoefW'($signed(regs_q[2*r+1][31:0]));
      m[r][3] = CoefW'($signed(regs_q[2*r+1][63:32]));
    end
    for (int p = 0; p < NumPlanes; p++) begin
      if (p == 0 || p == 3 || p == 4) begin
        derived[p].a = m[3][0] + m[p>>1][0];
        derived[p].b = m[3][1] + m[p>>1][1];
        derived[p].c = m[3][2] + m[p>>1][2];
        derived[p].d = m[3][3] + m[p>>1][3];
      end else begin
        derived[p].a = m[3][0] - m[p>>1][0];
        derived[p].b = m[3][1] - m[p>>1][1];
        derived[p].c = m[3][2] - m[p>>1][2];
        derived[p].d = m[3][3] - m[p>>1][3];
      end
    end
  end

  assign shift = (state_q == ST_RUN);

  // ring of plane cells, cell 0 feeds the evaluator
  for (genvar g = 0; g < NumPlanes; g++) begin : g_cell
    fct_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .load_i     (rebuild_q),
      .load_val_i (derived[g]),
      .shift_i    (shift),
      .prev_i     (ring[(g + 1) % NumPlanes]),
      .plane_o    (ring[g])
    );
  end

  fct_eval u_eval (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (shift),
    .plane_i (ring[0]),
    .op_i    (op_q),
    .vld_o   (ev_vld),
    .neg_o   (ev_neg)
  );

  // operand setup
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q.use_ext <= (func_i == FUNC_CUBE) || (func_i == FUNC_BOX);
      op_q.rk      <= (func_i == FUNC_SPHERE) ? 34'($signed({1'b0, radius_i})) : '0;
      if (func_i == FUNC_BOX) begin
        op_q.px <= 34'(x_i) + 34'(max_x_i);
        op_q.py <= 34'(y_i) + 34'(max_y_i);
        op_q.pz <= 34'(z_i) + 34'(max_z_i);
        op_q.ex <= 34'(max_x_i) - 34'(x_i);
        op_q.ey <= 34'(max_y_i) - 34'(y_i);
        op_q.ez <= 34'(max_z_i) - 34'(z_i);
        op_q.dk <= 34'sd1 <<< (FracBits + 1);
      end else begin
        op_q.px <= 34'(x_i);
        op_q.py <= 34'(y_i);
        op_q.pz <= 34'(z_i);
        op_q.ex <= 34'($signed({1'b0, radius_i}));
        op_q.ey <= 34'($signed({1'b0, radius_i}));
        op_q.ez <= 34'($signed({1'b0, radius_i}));
        op_q.dk <= 34'sd1 <<< FracBits;
      end
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: if (accept) begin
        state_d = ST_RUN;
        cnt_d   = '0;
      end
      ST_RUN: begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'(NumPlanes - 1)) state_d = ST_WAIT;
      end
      ST_WAIT: if (done_q) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      cull_q   <= 1'b0;
      pend_q   <= '0;
      done_q   <= 1'b0;
      inside_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= (pend_q == 2'd2);
      if (accept) begin
        cull_q <= 1'b0;
      end else if (ev_vld) begin
        cull_q <= cull_q | ev_neg;
      end
      if (state_q == ST_RUN && cnt_q == 3'(NumPlanes - 1)) pend_q <= 2'd1;
      else if (pend_q == 2'd1) pend_q <= 2'd2;
      else if (pend_q == 2'd2) begin
        pend_q   <= 2'd0;
        inside_q <= !(cull_q | (ev_vld & ev_neg));
      end
    end
  end

  assign done_o       = done_q;
  assign inside_res_o = inside_q;

  a_done_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == ST_WAIT) else $error("result outside wait");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o) else $error("busy not raised");
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  a_shift_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shift |-> cnt_q < 3'(NumPlanes)) else $error("ring overrun");

endmodule
`default_nettype wire

@@ hw/rtl/fct_cell.sv @@
`default_nettype none
// One storage cell of the plane ring: holds a plane and passes it on each shift.
module fct_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            load_i,
  input  wire fct_pkg::plane_t load_val_i,
  input  wire logic            shift_i,
  input  wire fct_pkg::plane_t prev_i,
  output fct_pkg::plane_t      plane_o
);
  import fct_pkg::*;

  plane_t plane_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q <= '0;
    end else if (load_i) begin
      plane_q <= load_val_i;
    end else if (shift_i) begin
      plane_q <= prev_i;
    end
  end

  assign plane_o = plane_q;
endmodule
`default_nettype wire

@@ hw/rtl/fct_eval.sv @@
`default_nettype none
// Plane evaluator: two stages, products registered then summed and sign taken.
module fct_eval (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            vld_i,
  input  wire fct_pkg::plane_t plane_i,
  input  wire fct_pkg::oper_t  op_i,
  output logic                 vld_o,
  output logic                 neg_o
);
  import fct_pkg::*;

  logic               vld_q;
  logic signed [67:0] pa_q, pb_q, pc_q, pd_q, ea_q, eb_q, ec_q;
  logic signed [67:0] rk_q;
  logic signed [SumW-1:0] sum;

  function automatic logic signed [33:0] absv(input logic signed [33:0] v);
    absv = v[33] ? -v : v;
  endfunction

  // stage 1: products
  always_ff @(posedge clk_i) begin
    pa_q <= plane_i.a * op_i.px;
    pb_q <= plane_i.b * op_i.py;
    pc_q <= plane_i.c * op_i.pz;
    pd_q <= plane_i.d * op_i.dk;
    ea_q <= op_i.use_ext ? absv(plane_i.a) * op_i.ex : 68'sd0;
    eb_q <= op_i.use_ext ? absv(plane_i.b) * op_i.ey : 68'sd0;
    ec_q <= op_i.use_ext ? absv(plane_i.c) * op_i.ez : 68'sd0;
    rk_q <= {{34{op_i.rk[33]}}, op_i.rk} <<< FracBits;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else vld_q <= vld_i;
  end

  // stage 2: sum
  always_comb begin
    sum = SumW'(pa_q) + SumW'(pb_q) + SumW'(pc_q) + SumW'(pd_q)
        + SumW'(ea_q) + SumW'(eb_q) + SumW'(ec_q) + SumW'(rk_q);
  end

  assign vld_o = vld_q;
  assign neg_o = sum[SumW-1];
endmodule
`default_nettype wire

@@ tb/tb_frustum_cull_test.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tb_frustum_cull_test;
  import fct_pkg::*;

  typedef logic signed [127:0] wide_t;

  localparam int Limit = 5000;
  localparam int DrainCycles = 20;
  localparam int ItemsPerPhase = 220;
  localparam longint OneFx = 64'sd65536;

  // one containment query
  typedef struct {
    func_e           func;
    logic signed [31:0] x, y, z;
    logic [30:0]     rad;
    logic signed [31:0] mx, my, mz;
    bit              known;
    bit              exp_in;
  } query_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [RegIdxW-1:0] cfg_idx_i = '0;
  logic [RegW-1:0] cfg_data_i = '0;
  logic start_i = 1'b0;
  logic busy_o;
  logic [1:0] func_i = '0;
  logic signed [31:0] x_i = '0, y_i = '0, z_i = '0;
  logic [30:0] radius_i = '0;
  logic signed [31:0] max_x_i = '0, max_y_i = '0, max_z_i = '0;
  logic done_o;
  logic inside_res_o;

  logic [RegW-1:0] matrix_regs [NumRegs];
  longint planes [NumPlanes][4];
  bit pending_inside [$];
  int mismatches = 0;
  int idle_pct = 0;
  int stall_count = 0;

  always #1 clk_i = ~clk_i;

  frustum_cull_test u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .start_i, .busy_o,
    .func_i, .x_i, .y_i, .z_i, .radius_i, .max_x_i, .max_y_i, .max_z_i,
    .done_o, .inside_res_o
  );

  // rebuild the six planes from the shadow matrix
  function automatic void rebuild_planes();
    longint m [4][4];
    int row;
    for (int r = 0; r < 4; r++) begin
      for (int k = 0; k < 2; k++) begin
        m[r][2*k]   = longint'(signed'(matrix_regs[2*r+k][31:0]));
        m[r][2*k+1] = longint'(signed'(matrix_regs[2*r+k][63:32]));
      end
    end
    for (int p = 0; p < NumPlanes; p++) begin
      row = (p >> 1) & 3;
      for (int k = 0; k < 4; k++) begin
        // left, bottom, near add the row; right, top, far subtract it
        if (p == 0 || p == 3 || p == 4) planes[p][k] = m[3][k] + m[row][k];
        else planes[p][k] = m[3][k] - m[row][k];
      end
    end
  endfunction

  function automatic longint absl(longint v);
    return v < 0 ? -v : v;
  endfunction

  // exact containment: any plane with a negative distance culls
  function automatic bit predict_inside(query_t q);
    wide_t acc;
    longint pos [3], hi [3];
    longint rad;
    bit ok;
    ok = 1'b1;
    pos = '{longint'(q.x), longint'(q.y), longint'(q.z)};
    hi  = '{longint'(q.mx), longint'(q.my), longint'(q.mz)};
    rad = longint'({1'b0, q.rad});
    for (int p = 0; p < NumPlanes; p++) begin
      if (q.func == FUNC_BOX) begin
        acc = wide_t'(planes[p][3]) * wide_t'(2 * OneFx);
        for (int k = 0; k < 3; k++) begin
          acc += wide_t'(planes[p][k]) * wide_t'(pos[k] + hi[k]);
          acc += wide_t'(absl(planes[p][k])) * wide_t'(hi[k] - pos[k]);
        end
      end else begin
        acc = wide_t'(planes[p][3]) * wide_t'(OneFx);
        for (int k = 0; k < 3; k++) begin
          acc += wide_t'(planes[p][k]) * wide_t'(pos[k]);
          if (q.func == FUNC_CUBE) acc += wide_t'(absl(planes[p][k])) * wide_t'(rad);
        end
        if (q.func == FUNC_SPHERE) acc += wide_t'(rad) * wide_t'(OneFx);
      end
      if (acc < 0) ok = 1'b0;
    end
    return ok;
  endfunction

  // wait for the block to go idle (no result may still be in flight)
  task automatic wait_idle();
    while (pending_inside.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [RegIdxW-1:0] idx, logic [RegW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    matrix_regs[idx] = val;
    rebuild_planes();
  endtask

  task automatic load_matrix(logic [RegW-1:0] v [NumRegs]);
    wait_idle();
    for (int i = 0; i < NumRegs; i++) write_reg(i[RegIdxW-1:0], v[i]);
    cfg_we_i <= 1'b0;
    repeat (3) @(posedge clk_i);
  endtask

  // one transaction, start held until accepted
  task automatic send_query(query_t q);
    bit want;
    func_i <= q.func;
    x_i <= q.x; y_i <= q.y; z_i <= q.z;
    radius_i <= q.rad;
    max_x_i <= q.mx; max_y_i <= q.my; max_z_i <= q.mz;
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    want = predict_inside(q);
    if (q.known && want != q.exp_in) begin
      mismatches++;
      if (mismatches <= 10)
        $display("table row disagrees with predictor: func %s table %0b pred %0b",
                 q.func.name(), q.exp_in, want);
    end
    pending_inside.push_back(want);
    if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(3, 0))
      0: return $urandom;
      1: return $urandom_range(32'h0004_0000, 0) - 32'sh0002_0000;
      2: return $urandom_range(32'h0000_4000, 0) - 32'sh0000_2000;
      default: return $urandom_range(32'h0000_0400, 0) - 32'sh0000_0200;
    endcase
  endfunction

  function automatic query_t rand_query();
    query_t q;
    q.func = func_e'($urandom_range(3, 0));
    q.x = rand_coord(); q.y = rand_coord(); q.z = rand_coord();
    q.rad = ($urandom_range(1, 0) != 0) ? 31'($urandom) : 31'($urandom_range(32'h3_0000, 0));
    // box max mostly near the min, sometimes anywhere (inverted included)
    if ($urandom_range(3, 0) != 0) begin
      q.mx = q.x + $urandom_range(32'h2_0000, 0);
      q.my = q.y + $urandom_range(32'h2_0000, 0);
      q.mz = q.z + $urandom_range(32'h2_0000, 0);
    end else begin
      q.mx = rand_coord(); q.my = rand_coord(); q.mz = rand_coord();
    end
    q.known = 1'b0;
    q.exp_in = 1'b0;
    return q;
  endfunction

  // matrix with entries of bounded size; wide=1 means full 32-bit range
  function automatic void rand_matrix(output logic [RegW-1:0] v [NumRegs], input bit wide);
    for (int i = 0; i < NumRegs; i++) begin
      if (wide) v[i] = {$urandom, $urandom};
      else v[i] = {32'($urandom_range(32'h4_0000, 0) - 32'sh2_0000),
                   32'($urandom_range(32'h4_0000, 0) - 32'sh2_0000)};
    end
  endfunction

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_inside.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result inside=%0b", inside_res_o);
      end else begin
        if (inside_res_o !== pending_inside[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("inside mismatch: expected %0b actual %0b",
                     pending_inside[0], inside_res_o);
        end
        void'(pending_inside.pop_front());
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || done_o || cfg_we_i || (start_i && !busy_o)) stall_count <= 0;
    else stall_count <= stall_count + 1;
    if (stall_count >= Limit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    query_t table_rows [$];
    logic [RegW-1:0] mat [NumRegs];
    int phase_idle [4];
    phase_idle = '{0, 75, 0, 32};
    matrix_regs = RegReset;
    rebuild_planes();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed rows against the identity frustum
    table_rows = '{
      '{FUNC_POINT, 0, 0, 0, 0, 0, 0, 0, 1, 1},
      '{FUNC_POINT, 32'sh2_0000, 0, 0, 0, 0, 0, 0, 1, 0},
      '{FUNC_POINT, 32'sh1_0000, 32'sh1_0000, 32'sh1_0000, 0, 0, 0, 0, 1, 1},
      '{FUNC_POINT, 32'sh8000_0000, 0, 0, 0, 0, 0, 0, 1, 0},
      '{FUNC_POINT, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 0, 0, 0, 0, 1, 0},
      '{FUNC_SPHERE, 32'sh2_0000, 0, 0, 31'h1_8000, 0, 0, 0, 1, 1},
      '{FUNC_SPHERE, 32'sh3_0000, 0, 0, 31'h1_0000, 0, 0, 0, 1, 0},
      '{FUNC_SPHERE, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 31'h7fff_ffff,
        0, 0, 0, 0, 0},
      '{FUNC_CUBE, 32'sh3_0000, 0, 0, 31'h1_0000, 0, 0, 0, 1, 0},
      '{FUNC_CUBE, 32'sh2_0000, 0, 0, 31'h1_0000, 0, 0, 0, 1, 1},
      '{FUNC_CUBE, 32'sh7fff_ffff, 32'sh8000_0000, 0, 31'h7fff_ffff, 0, 0, 0, 0, 0},
      '{FUNC_BOX, -32'sh1_0000, -32'sh1_0000, -32'sh1_0000, 0,
        32'sh1_0000, 32'sh1_0000, 32'sh1_0000, 1, 1},
      '{FUNC_BOX, 32'sh2_0000, 32'sh2_0000, 0, 0, 32'sh3_0000, 32'sh3_0000, 0, 1, 0},
      // inverted box: max below min
      '{FUNC_BOX, 32'sh1_0000, 0, 0, 0, -32'sh1_0000, 0, 0, 0, 0},
      '{FUNC_BOX, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 31'h7fff_ffff,
        32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 0, 0}
    };
    foreach (table_rows[i]) send_query(table_rows[i]);
    start_i <= 1'b0;

    // zero matrix: every distance is zero, nothing culls
    mat = '{default: '0};
    load_matrix(mat);
    send_query('{FUNC_POINT, 32'sh7fff_ffff, 0, 0, 0, 0, 0, 0, 1, 1});
    send_query('{FUNC_BOX, 0, 0, 0, 0, -32'sh1, -32'sh1, -32'sh1, 0, 0});
    start_i <= 1'b0;

    // random phases over several matrices and sender idling
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: mat = RegReset;
        1: rand_matrix(mat, 1'b0);
        2: mat = '{default: 64'h8000_0000_8000_0000};
        3: mat = '{default: 64'h7fff_ffff_7fff_ffff};
        default: rand_matrix(mat, 1'b1);
      endcase
      load_matrix(mat);
      idle_pct = phase_idle[ph % 4];
      for (int n = 0; n < ItemsPerPhase; n++) begin
        send_query(rand_query());
        // hold off until the pipe drains
        if (n == ItemsPerPhase / 2) begin
          start_i <= 1'b0;
          while (pending_inside.size() != 0) @(posedge clk_i);
        end
      end
      start_i <= 1'b0;
    end
    idle_pct = 0;

    while (pending_inside.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
`default_nettype wire
